// ===== src/block_bitmap_allocator_top_assert.svh =====
// Assertion macros used by the block bitmap allocator sequencer.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

// ===== src/bba_pkg.sv =====
// Shared types and constants of the block bitmap allocator.
`default_nettype none

package bba_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned BLK_W     = 12;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TDATA_W   = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_DOUBLE = 2'd2,
    STAT_RANGE  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Verdict of the word unit on the word under evaluation.
  typedef struct packed {
    logic found;    // a free block below the count lies in this word
    logic last;     // this word reaches the block count
    logic in_word;  // the block to free lies in this word
    logic hit;      // the block to free is marked in use
  } word_flags_t;

endpackage

`default_nettype wire

// ===== src/bba_bitmap_mem.sv =====
// Usage bitmap storage: one word per row, per-row valid bits, registered read.
`default_nettype none

module bba_bitmap_mem #(
  parameter int unsigned NWORDS    = 64,
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned WIW       = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rd_en_i,
  input  wire logic [WIW-1:0]       rd_addr_i,
  output      logic [WORD_BITS-1:0] rd_word_o,
  input  wire logic                 wr_en_i,
  input  wire logic [WIW-1:0]       wr_addr_i,
  input  wire logic [WORD_BITS-1:0] wr_word_i
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    row_vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      rvld_q  <= row_vld_q[rd_addr_i];
    end
  end

  // A row never written reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en_i) begin
      row_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_word_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== src/bba_word_unit.sv =====
// Shared word evaluator: first-free search, range mask and bit update.
`default_nettype none

module bba_word_unit
  import bba_pkg::*;
#(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned NW        = 13
) (
  input  wire logic [WORD_BITS-1:0]         word_i,
  input  wire logic [NW-1:0]                base_i,
  input  wire logic [NW-1:0]                count_i,
  input  wire logic [NW-1:0]                blk_i,
  input  wire logic                         kind_i,
  output      word_flags_t                  flags_o,
  output      logic [$clog2(WORD_BITS)-1:0] idx_o,
  output      logic [WORD_BITS-1:0]         new_word_o
);

  localparam int unsigned BOW = $clog2(WORD_BITS);
  localparam logic [NW-1:0] WB = NW'(WORD_BITS);

  logic [NW-1:0]        top;
  logic [NW-1:0]        lim;
  logic [NW-1:0]        rel;
  logic [BOW-1:0]       off;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_v;
  logic [WORD_BITS-1:0] onehot;
  logic [BOW-1:0]       idx;

  always_comb begin
    top = base_i + WB;
    lim = (count_i > base_i) ? (count_i - base_i) : '0;
    rel = blk_i - base_i;
    off = rel[BOW-1:0];

    // Only blocks below the count take part in the search.
    if (lim >= WB) begin
      mask = '1;
    end else begin
      mask = ~({WORD_BITS{1'b1}} << lim[BOW-1:0]);
    end

    free_v = ~word_i & mask;
    onehot = free_v & (~free_v + WORD_BITS'(1));

    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | BOW'(i);
      end
    end

    flags_o.found   = |free_v;
    flags_o.last    = (top >= count_i);
    flags_o.in_word = (blk_i < top);
    flags_o.hit     = flags_o.in_word & word_i[off];

    if (kind_i == KIND_ALLOC) begin
      new_word_o = word_i | onehot;
    end else begin
      new_word_o = word_i & ~(WORD_BITS'(1) << off);
    end
    idx_o = idx;
  end

endmodule

`default_nettype wire

// ===== src/bba_seq.sv =====
// Sequencer: walks the bitmap one word a cycle and forms the result.
`default_nettype none
`include "block_bitmap_allocator_top_assert.svh"

module bba_seq
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned WORD_BITS  = 64,
  parameter int unsigned NWORDS     = 64,
  parameter int unsigned WIW        = 6,
  parameter int unsigned NW         = 13
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         in_kind_i,
  input  wire logic [BLK_W-1:0]             in_blk_i,
  input  wire logic [CFG_W-1:0]             cfg_count_i,
  output      logic                         rd_en_o,
  output      logic [WIW-1:0]               rd_addr_o,
  output      logic                         wr_en_o,
  output      logic [WIW-1:0]               wr_addr_o,
  output      logic [NW-1:0]                ev_base_o,
  output      logic [NW-1:0]                ev_count_o,
  output      logic [NW-1:0]                ev_blk_o,
  output      logic                         ev_kind_o,
  input  wire word_flags_t                  flags_i,
  input  wire logic [$clog2(WORD_BITS)-1:0] idx_i,
  output      logic                         res_valid_o,
  input  wire logic                         res_ready_i,
  output      logic [BLK_W-1:0]             res_block_o,
  output      status_e                      res_status_o
);

  localparam logic [NW-1:0]  MAXB     = NW'(MAX_BLOCKS);
  localparam logic [NW-1:0]  WB       = NW'(WORD_BITS);
  localparam logic [WIW-1:0] LAST_ROW = WIW'(NWORDS - 1);

  state_e            state_q, state_d;
  logic              kind_q, kind_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [NW-1:0]     count_q, count_d;
  logic [WIW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]     rd_base_q, rd_base_d;
  logic              ev_q, ev_d;
  logic [WIW-1:0]    ev_ptr_q, ev_ptr_d;
  logic [NW-1:0]     ev_base_q, ev_base_d;
  logic [BLK_W-1:0]  res_block_q, res_block_d;
  status_e           res_status_q, res_status_d;

  logic              accept;
  logic [NW-1:0]     cnt_act;
  logic              early_range;
  logic              ev_finish;
  logic [NW-1:0]     grant_full;

  always_comb begin
    accept      = in_valid_i & (state_q == S_IDLE);
    cnt_act     = (NW'(cfg_count_i) > MAXB) ? MAXB : NW'(cfg_count_i);
    early_range = (in_kind_i == KIND_FREE) & (NW'(in_blk_i) >= cnt_act);
    grant_full  = ev_base_q + NW'(idx_i);
    if (kind_q == KIND_ALLOC) begin
      ev_finish = ev_q & (flags_i.found | flags_i.last);
    end else begin
      ev_finish = ev_q & flags_i.in_word;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = early_range ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (ev_finish) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    kind_d       = kind_q;
    blk_d        = blk_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    rd_base_d    = rd_base_q;
    ev_d         = 1'b0;
    ev_ptr_d     = ev_ptr_q;
    ev_base_d    = ev_base_q;
    res_block_d  = res_block_q;
    res_status_d = res_status_q;
    in_ready_o   = 1'b0;
    rd_en_o      = 1'b0;
    wr_en_o      = 1'b0;
    res_valid_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          kind_d       = in_kind_i;
          blk_d        = in_blk_i;
          count_d      = cnt_act;
          rd_ptr_d     = '0;
          rd_base_d    = '0;
          res_block_d  = '0;
          res_status_d = STAT_RANGE;
        end
      end
      S_SCAN: begin
        // Issue the next row read while the previous row is evaluated.
        rd_en_o   = 1'b1;
        ev_d      = ~ev_finish;
        ev_ptr_d  = rd_ptr_q;
        ev_base_d = rd_base_q;
        if (rd_ptr_q != LAST_ROW) begin
          rd_ptr_d  = rd_ptr_q + WIW'(1);
          rd_base_d = rd_base_q + WB;
        end
        if (ev_q) begin
          if (kind_q == KIND_ALLOC) begin
            if (flags_i.found) begin
              wr_en_o      = 1'b1;
              res_block_d  = grant_full[BLK_W-1:0];
              res_status_d = STAT_OK;
            end else if (flags_i.last) begin
              res_status_d = STAT_FULL;
            end
          end else if (flags_i.in_word) begin
            wr_en_o      = flags_i.hit;
            res_status_d = flags_i.hit ? STAT_OK : STAT_DOUBLE;
          end
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ev_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    blk_q        <= blk_d;
    count_q      <= count_d;
    rd_ptr_q     <= rd_ptr_d;
    rd_base_q    <= rd_base_d;
    ev_ptr_q     <= ev_ptr_d;
    ev_base_q    <= ev_base_d;
    res_block_q  <= res_block_d;
    res_status_q <= res_status_d;
  end

  assign rd_addr_o    = rd_ptr_q;
  assign wr_addr_o    = ev_ptr_q;
  assign ev_base_o    = ev_base_q;
  assign ev_count_o   = count_q;
  assign ev_blk_o     = NW'(blk_q);
  assign ev_kind_o    = kind_q;
  assign res_block_o  = res_block_q;
  assign res_status_o = res_status_q;

  `BBA_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, accept, state_q != S_IDLE)
  `BBA_ASSERT_NOW(a_count_saturated, clk_i, rst_ni, state_q != S_IDLE, count_q <= MAXB)
  `BBA_ASSERT_NOW(a_scan_below_count, clk_i, rst_ni, ev_q && state_q == S_SCAN, (ev_base_q < count_q) || (ev_base_q == '0))
  `BBA_ASSERT_NEXT(a_grant_in_range, clk_i, rst_ni, wr_en_o && kind_q == KIND_ALLOC, NW'(res_block_q) < count_q && res_status_q == STAT_OK)

endmodule

`default_nettype wire

// ===== src/block_bitmap_allocator_top.sv =====
// Top level of the first-fit block bitmap allocator.
//
//  channel   direction  payload (lowest bit first)              handshake
//  s_axis    in         tdata: block_number, tuser: kind        tvalid/tready
//  m_axis    out        tdata: granted_block, tuser: status     tvalid/tready
//  cfg       in         data: blocks_in_use                     valid/ready
//
//  An allocate or an in-range free scans the bitmap: the sequencer reads
//  one bitmap row a cycle through the single memory read port and the
//  shared word unit judges it in the cycle after.
//  A free beyond the block count finishes without a scan.
//  Reset marks every row as unwritten through per-row valid bits, so the
//  bitmap reads all free at once; no clearing pass runs.
//  The result waits in an output register; the next item is accepted once
//  the result has moved there, whether or not m_axis has taken it yet.
`default_nettype none

module block_bitmap_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned WORD_BITS  = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [TDATA_W-1:0]  s_axis_tdata,   // [11:0] block_number
  input  wire logic                s_axis_tuser,   // [0] kind
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [TDATA_W-1:0]  m_axis_tdata,   // [11:0] granted_block
  output      logic [STATUS_W-1:0] m_axis_tuser,   // [1:0] status
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CFG_W-1:0]    cfg_data_i      // [12:0] blocks_in_use
);

  localparam int unsigned NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned SPAN_W = $clog2(NWORDS * WORD_BITS + 1);
  localparam int unsigned NW     = (SPAN_W > CFG_W) ? SPAN_W : CFG_W;
  localparam int unsigned BOW    = $clog2(WORD_BITS);

  logic [CFG_W-1:0]     blocks_q;
  logic                 m_valid_q, m_valid_d;
  logic [BLK_W-1:0]     m_block_q;
  status_e              m_status_q;

  logic                 rd_en, wr_en;
  logic [WIW-1:0]       rd_addr, wr_addr;
  logic [WORD_BITS-1:0] rd_word, new_word;
  logic [NW-1:0]        ev_base, ev_count, ev_blk;
  logic                 ev_kind;
  word_flags_t          flags;
  logic [BOW-1:0]       idx;
  logic                 res_valid, res_ready;
  logic [BLK_W-1:0]     res_block;
  status_e              res_status;

  // Block count register, always ready. The sequencer latches its own copy
  // of the count when it takes an item, so a write never reaches an item
  // already in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      blocks_q <= cfg_data_i;
    end
  end

  bba_bitmap_mem #(
    .NWORDS    (NWORDS),
    .WORD_BITS (WORD_BITS),
    .WIW       (WIW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_word_o (rd_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_word_i (new_word)
  );

  bba_word_unit #(
    .WORD_BITS (WORD_BITS),
    .NW        (NW)
  ) u_word (
    .word_i     (rd_word),
    .base_i     (ev_base),
    .count_i    (ev_count),
    .blk_i      (ev_blk),
    .kind_i     (ev_kind),
    .flags_o    (flags),
    .idx_o      (idx),
    .new_word_o (new_word)
  );

  bba_seq #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS),
    .NWORDS     (NWORDS),
    .WIW        (WIW),
    .NW         (NW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_blk_i     (s_axis_tdata[BLK_W-1:0]),
    .cfg_count_i  (blocks_q),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .ev_base_o    (ev_base),
    .ev_count_o   (ev_count),
    .ev_blk_o     (ev_blk),
    .ev_kind_o    (ev_kind),
    .flags_i      (flags),
    .idx_i        (idx),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_block_o  (res_block),
    .res_status_o (res_status)
  );

  // Output register: load a finished item whenever the slot is free or
  // drains in this cycle; hold it otherwise.
  assign res_ready = ~m_valid_q | m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid & res_ready) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid & res_ready) begin
      m_block_q  <= res_block;
      m_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'(m_block_q);
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire
